/* rtl/cpt_pkg.sv */
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and constants of the connection pair table
// Transfer payloads, stored pair layout, status codes and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  localparam int unsigned InstW  = 16;
  localparam int unsigned CompW  = 8;
  localparam int unsigned QueueW = 16;
  localparam int unsigned IndexW = 4;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_FIND = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RES_ADD_OK,
    RES_FULL,
    RES_FOUND,
    RES_MISS
  } result_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_READ,
    ST_CMP
  } state_e;

  typedef struct packed {
    logic              req_type;
    logic [InstW-1:0]  first_instance;
    logic [CompW-1:0]  first_component;
    logic [QueueW-1:0] first_queue;
    logic [InstW-1:0]  second_instance;
    logic [CompW-1:0]  second_component;
    logic [QueueW-1:0] second_queue;
    logic [InstW-1:0]  sender_instance;
    logic [CompW-1:0]  dest_component;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [QueueW-1:0] receiver_queue;
    logic [IndexW-1:0] entry_index;
  } out_t;

  typedef struct packed {
    logic [InstW-1:0]  inst1;
    logic [CompW-1:0]  comp1;
    logic [QueueW-1:0] queue1;
    logic [InstW-1:0]  inst2;
    logic [CompW-1:0]  comp2;
    logic [QueueW-1:0] queue2;
  } pair_t;

  typedef struct packed {
    logic    load;
    logic    wr;
    logic    rd;
    logic    adv;
    logic    fin;
    result_e kind;
  } cmd_t;

  typedef struct packed {
    logic is_find;
    logic full;
    logic scan_end;
    logic match;
    logic out_free;
  } stat_t;

endpackage

/* rtl/cpt_ctrl.sv */
// ----------------------------------------------------------------------------
// cpt_ctrl: sequencer of the connection pair table
// Accepts one request at a time, then steps the datapath through the add
// write or the entry-by-entry find scan.
// ----------------------------------------------------------------------------
module cpt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cpt_pkg::stat_t stat_i,
  output cpt_pkg::cmd_t  cmd_o
);

  cpt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cpt_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = cpt_pkg::ST_DECIDE;
      end
      cpt_pkg::ST_DECIDE: begin
        if (stat_i.is_find) begin
          state_d = cpt_pkg::ST_READ;
        end else if (stat_i.out_free) begin
          state_d = cpt_pkg::ST_IDLE;
        end
      end
      cpt_pkg::ST_READ: begin
        if (!stat_i.scan_end) begin
          state_d = cpt_pkg::ST_CMP;
        end else if (stat_i.out_free) begin
          state_d = cpt_pkg::ST_IDLE;
        end
      end
      cpt_pkg::ST_CMP: begin
        if (!stat_i.match) begin
          state_d = cpt_pkg::ST_READ;
        end else if (stat_i.out_free) begin
          state_d = cpt_pkg::ST_IDLE;
        end
      end
      default: state_d = cpt_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = cpt_pkg::RES_ADD_OK;
    in_stall_o = 1'b1;
    unique case (state_q)
      cpt_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      cpt_pkg::ST_DECIDE: begin
        if (!stat_i.is_find && stat_i.out_free) begin
          cmd_o.fin = 1'b1;
          if (stat_i.full) begin
            cmd_o.kind = cpt_pkg::RES_FULL;
          end else begin
            cmd_o.wr   = 1'b1;
            cmd_o.kind = cpt_pkg::RES_ADD_OK;
          end
        end
      end
      cpt_pkg::ST_READ: begin
        if (!stat_i.scan_end) begin
          cmd_o.rd = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.fin  = 1'b1;
          cmd_o.kind = cpt_pkg::RES_MISS;
        end
      end
      cpt_pkg::ST_CMP: begin
        if (!stat_i.match) begin
          cmd_o.adv = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.fin  = 1'b1;
          cmd_o.kind = cpt_pkg::RES_FOUND;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/cpt_dp.sv */
// ----------------------------------------------------------------------------
// cpt_dp: datapath of the connection pair table
// Pair memory, fill count, scan pointer, endpoint compare and the result
// register toward the output channel.
// ----------------------------------------------------------------------------
module cpt_dp #(
  parameter int unsigned ENTRIES = cpt_pkg::ENTRIES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cpt_pkg::in_t   in_data_i,
  input  cpt_pkg::cmd_t  cmd_i,
  output cpt_pkg::stat_t stat_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cpt_pkg::out_t  out_data_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  cpt_pkg::pair_t mem [ENTRIES];

  cpt_pkg::in_t   req_q;
  cpt_pkg::pair_t rdata_q;
  logic [CntW-1:0] count_q, ptr_q;
  logic           out_valid_q;
  cpt_pkg::out_t  out_q, out_d;

  logic                         match1, match2;
  logic [cpt_pkg::QueueW-1:0]   hit_queue;
  logic [IdxW+cpt_pkg::IndexW-1:0] wr_idx_ext, ptr_idx_ext;

  // Entries are never freed, so the valid entries are exactly 0 .. count-1.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr) count_q <= count_q + CntW'(1);
      if (cmd_i.load) begin
        ptr_q <= '0;
      end else if (cmd_i.adv) begin
        ptr_q <= ptr_q + CntW'(1);
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_data_i;
    if (cmd_i.fin) out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[count_q[IdxW-1:0]] <= '{
        inst1:  req_q.first_instance,
        comp1:  req_q.first_component,
        queue1: req_q.first_queue,
        inst2:  req_q.second_instance,
        comp2:  req_q.second_component,
        queue2: req_q.second_queue
      };
    end
    if (cmd_i.rd) rdata_q <= mem[ptr_q[IdxW-1:0]];
  end

  // Side one as sender wins over side two.
  assign match1 = (rdata_q.inst1 == req_q.sender_instance) &&
                  (rdata_q.comp2 == req_q.dest_component);
  assign match2 = (rdata_q.inst2 == req_q.sender_instance) &&
                  (rdata_q.comp1 == req_q.dest_component);
  assign hit_queue = match1 ? rdata_q.queue2 : rdata_q.queue1;

  assign wr_idx_ext  = {{cpt_pkg::IndexW{1'b0}}, count_q[IdxW-1:0]};
  assign ptr_idx_ext = {{cpt_pkg::IndexW{1'b0}}, ptr_q[IdxW-1:0]};

  always_comb begin
    out_d = '0;
    unique case (cmd_i.kind)
      cpt_pkg::RES_ADD_OK: begin
        out_d.status      = cpt_pkg::STATUS_OK;
        out_d.entry_index = wr_idx_ext[cpt_pkg::IndexW-1:0];
      end
      cpt_pkg::RES_FULL: begin
        out_d.status = cpt_pkg::STATUS_FULL;
      end
      cpt_pkg::RES_FOUND: begin
        out_d.status         = cpt_pkg::STATUS_OK;
        out_d.receiver_queue = hit_queue;
        out_d.entry_index    = ptr_idx_ext[cpt_pkg::IndexW-1:0];
      end
      cpt_pkg::RES_MISS: begin
        out_d.status = cpt_pkg::STATUS_NOT_FOUND;
      end
      default: ;
    endcase
  end

  assign stat_o.is_find  = (req_q.req_type == cpt_pkg::REQ_FIND);
  assign stat_o.full     = (count_q == CntW'(ENTRIES));
  assign stat_o.scan_end = (ptr_q == count_q);
  assign stat_o.match    = match1 | match2;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/connection_pair_table_top.sv */
// ----------------------------------------------------------------------------
// connection_pair_table_top: bidirectional connection pair table
// Stores endpoint pairs on add requests and looks up the receiver queue of
// a sender instance and destination component on find requests.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  cpt_pkg::in_t  in_data_i
//   out      output     out_valid_o / out_stall_i cpt_pkg::out_t out_data_o
//
// An add captures the request, then writes the pair and registers the result.
// A find walks the single-port pair memory one entry per read/compare pair
// until it hits. A find that misses ends in a last read step that sees the
// scan reach the fill count.
// Reset clears the fill count, the controller and the output valid; the pair
// memory is not cleared, since only entries below the fill count are read.
// A stalled output holds its result; the next request is still taken and
// runs up to the point where it needs the output register.
// ----------------------------------------------------------------------------
module connection_pair_table_top #(
  parameter int unsigned ENTRIES = cpt_pkg::ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cpt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cpt_pkg::out_t out_data_o
);

  cpt_pkg::cmd_t  cmd;
  cpt_pkg::stat_t stat;

  // Sequence each transfer: capture, then write or scan.
  cpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold the table and produce the result transfer.
  cpt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/connection_pair_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_pair_table_checker: result predictor and scoreboard
// Watches both channels of the pair table, keeps its own copy of the entry
// flags and stored pairs, predicts the result of every accepted request and
// compares each result transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module connection_pair_table_checker #(
  parameter int unsigned ENTRIES = cpt_pkg::ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  cpt_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  cpt_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o
);

  logic           slot_used [ENTRIES];
  cpt_pkg::pair_t slot_pair [ENTRIES];
  cpt_pkg::out_t  route_q [$];
  int             mismatches = 0;

  assign fail_count_o = mismatches;

  // Compute the result of one request and apply its effect on the table.
  function automatic cpt_pkg::out_t route_lookup(cpt_pkg::in_t req);
    cpt_pkg::out_t res;
    res = '0;
    if (req.req_type == cpt_pkg::REQ_ADD) begin
      res.status = cpt_pkg::STATUS_FULL;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!slot_used[i]) begin
          slot_used[i] = 1'b1;
          slot_pair[i] = {req.first_instance, req.first_component, req.first_queue,
                          req.second_instance, req.second_component, req.second_queue};
          res.status      = cpt_pkg::STATUS_OK;
          res.entry_index = cpt_pkg::IndexW'(i);
          return res;
        end
      end
      return res;
    end
    res.status = cpt_pkg::STATUS_NOT_FOUND;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i]) begin
        // side one is tried as the sender before side two
        if (slot_pair[i].inst1 == req.sender_instance &&
            slot_pair[i].comp2 == req.dest_component) begin
          res.status         = cpt_pkg::STATUS_OK;
          res.receiver_queue = slot_pair[i].queue2;
          res.entry_index    = cpt_pkg::IndexW'(i);
          return res;
        end
        if (slot_pair[i].inst2 == req.sender_instance &&
            slot_pair[i].comp1 == req.dest_component) begin
          res.status         = cpt_pkg::STATUS_OK;
          res.receiver_queue = slot_pair[i].queue1;
          res.entry_index    = cpt_pkg::IndexW'(i);
          return res;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    cpt_pkg::out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      route_q.delete();
      pending_o <= 0;
    end else begin
      // retire the older result before queuing a new request
      if (out_valid_i && !out_stall_i) begin
        if (route_q.size() == 0) begin
          $error("unexpected result: status %0d receiver_queue %h entry_index %0d",
                 out_data_i.status, out_data_i.receiver_queue, out_data_i.entry_index);
          mismatches++;
        end else begin
          want = route_q.pop_front();
          if (out_data_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data_i.status);
            mismatches++;
          end
          if (out_data_i.receiver_queue !== want.receiver_queue) begin
            $error("receiver_queue: expected %h, actual %h",
                   want.receiver_queue, out_data_i.receiver_queue);
            mismatches++;
          end
          if (out_data_i.entry_index !== want.entry_index) begin
            $error("entry_index: expected %0d, actual %0d",
                   want.entry_index, out_data_i.entry_index);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) route_q.push_back(route_lookup(in_data_i));
      pending_o <= route_q.size();
    end
  end

endmodule

/* tb/connection_pair_table_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_pair_table_top_test: stimulus and verdict for the pair table
// Fills the table with directed and pooled endpoint pairs, overflows it, then
// issues random lookups whose ids mostly come from a small pool so that hits,
// misses, duplicate entries and both sender sides are all reached. Both
// channels idle at random; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module connection_pair_table_top_test;

  localparam int unsigned RANDOM_ITEMS = 1826;
  localparam int unsigned MAX_GAP      = 18;
  // longest quiet stretch of a correct run: a sender gap,
  // a full missed scan and a receiver stall back to back
  localparam int unsigned IDLE_LIMIT   = 1000;
  // margin for a find that misses on a full table
  localparam int unsigned DRAIN_CYCLES = 3 + 2 * cpt_pkg::ENTRIES_DEF + 5;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  cpt_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  cpt_pkg::out_t out_data;
  int            fail_count;
  int            pending;
  int            idle_cycles = 0;
  bit            gapless     = 1'b0;

  always #2 clk = ~clk;

  connection_pair_table_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  connection_pair_table_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Small id pools make stored pairs collide with lookups; the extremes of
  // both fields are part of each pool.
  function automatic logic [cpt_pkg::InstW-1:0] pick_instance();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 16'h1234;
      3:       return 16'h5678;
      4:       return 16'h0A0A;
      5:       return 16'h8001;
      6:       return 16'h00FF;
      default: return 16'h7F00;
    endcase
  endfunction

  function automatic logic [cpt_pkg::CompW-1:0] pick_component();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 8'h11;
      3:       return 8'h22;
      4:       return 8'h33;
      default: return 8'h80;
    endcase
  endfunction

  // Fill every field with random bits; callers then set what matters.
  function automatic cpt_pkg::in_t noise_request();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[$bits(cpt_pkg::in_t)-1:0];
  endfunction

  function automatic cpt_pkg::in_t add_request(
    logic [cpt_pkg::InstW-1:0] inst1, logic [cpt_pkg::CompW-1:0] comp1,
    logic [cpt_pkg::QueueW-1:0] queue1, logic [cpt_pkg::InstW-1:0] inst2,
    logic [cpt_pkg::CompW-1:0] comp2, logic [cpt_pkg::QueueW-1:0] queue2);
    cpt_pkg::in_t req;
    req = noise_request();
    req.req_type         = cpt_pkg::REQ_ADD;
    req.first_instance   = inst1;
    req.first_component  = comp1;
    req.first_queue      = queue1;
    req.second_instance  = inst2;
    req.second_component = comp2;
    req.second_queue     = queue2;
    return req;
  endfunction

  function automatic cpt_pkg::in_t find_request(logic [cpt_pkg::InstW-1:0] sender,
                                                logic [cpt_pkg::CompW-1:0] dest);
    cpt_pkg::in_t req;
    req = noise_request();
    req.req_type        = cpt_pkg::REQ_FIND;
    req.sender_instance = sender;
    req.dest_component  = dest;
    return req;
  endfunction

  // Mostly pooled lookups; the rest is pure noise, adds and finds alike.
  function automatic cpt_pkg::in_t random_request();
    cpt_pkg::in_t req;
    req = noise_request();
    if ($urandom_range(0, 4) != 0) begin
      req.req_type = cpt_pkg::REQ_FIND;
      if ($urandom_range(0, 3) != 0) req.sender_instance = pick_instance();
      if ($urandom_range(0, 3) != 0) req.dest_component = pick_component();
    end
    return req;
  endfunction

  // Idle for a random gap, then hold the request until its transfer.
  task automatic send(cpt_pkg::in_t req);
    int unsigned gap;
    gap = gapless ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold off until every predicted result has come back.
  // The first edge lets the checker count the last request transfer.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: stall for a random count before each result, then take it.
  initial begin : result_sink
    int unsigned hold;
    @(posedge rst_n);
    forever begin
      hold = gapless ? 0 : $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Count cycles without any transfer on either channel.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    cpt_pkg::in_t req;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lookup on an empty table misses
    send(find_request(16'h1234, 8'h11));
    // entry 0: all zero pair, lookup fields all ones and ignored
    req = add_request('0, '0, '0, '0, '0, '0);
    req.sender_instance = '1;
    req.dest_component  = '1;
    send(req);
    // entry 1: all ones pair, lookup fields all zero and ignored
    req = add_request('1, '1, '1, '1, '1, '1);
    req.sender_instance = '0;
    req.dest_component  = '0;
    send(req);
    // entry 2: plain pair
    send(add_request(16'h1234, 8'h11, 16'hAAAA, 16'h5678, 8'h22, 16'h5555));
    // entry 3: both sides match the same lookup
    send(add_request(16'h0A0A, 8'h33, 16'h1111, 16'h0A0A, 8'h33, 16'h2222));
    // entry 4: duplicate of entry 2 with other queues
    send(add_request(16'h1234, 8'h11, 16'hBBBB, 16'h5678, 8'h22, 16'h6666));
    // fill the rest from the pools
    repeat (cpt_pkg::ENTRIES_DEF - 5) begin
      send(add_request(pick_instance(), pick_component(), cpt_pkg::QueueW'($urandom),
                       pick_instance(), pick_component(), cpt_pkg::QueueW'($urandom)));
    end
    // table full: drop the add
    send(noise_request() &
         ~cpt_pkg::in_t'({1'b1, {($bits(cpt_pkg::in_t) - 1){1'b0}}}));
    // lowest duplicate wins, sender on side one
    send(find_request(16'h1234, 8'h22));
    // sender on side two
    send(find_request(16'h5678, 8'h11));
    // side one beats side two within an entry
    send(find_request(16'h0A0A, 8'h33));
    send(find_request('0, '0));
    send(find_request('1, '1));
    // ids outside every pool miss
    send(find_request(16'h9999, 8'h77));

    // pause the sender until the table has answered everything
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // switch between idling and back-to-back stretches
      if (n % 200 == 0) gapless <= ($urandom_range(0, 3) == 0);
      if (n % 450 == 449) wait_drained();
      send(random_request());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cpt_pkg.sv
rtl/cpt_ctrl.sv
rtl/cpt_dp.sv
rtl/connection_pair_table_top.sv
tb/connection_pair_table_checker.sv
tb/connection_pair_table_top_test.sv
